FILE: sv/tmn_pkg.sv
// Package for the tridiagonal matrix norm block: widths, mode codes,
// queue entry type, square-root state type and the magnitude function.
// No dependencies; every other file of the block imports it.
`default_nettype none

package tmn_pkg;

  // Field and datapath widths
  localparam int DataWidth  = 24;               // signed Q8.16 entries
  localparam int MagWidth   = DataWidth;        // magnitude incl. 2^(DataWidth-1)
  localparam int SqWidth    = 2 * MagWidth;     // one squared magnitude
  localparam int SqSumWidth = SqWidth + 2;      // sum of three squares
  localparam int AccWidth   = 64;               // saturating sum of squares
  localparam int MaxWidth   = MagWidth + 1;     // running max / line sums
  localparam int NormWidth  = 29;               // result, 16 fraction bits
  localparam int ModeWidth  = 3;
  localparam int RootWidth  = AccWidth / 2;
  localparam int CntWidth   = $clog2(RootWidth);

  // Queue between front and back
  localparam int FifoDepth  = 4;
  localparam int FifoAw     = $clog2(FifoDepth);

  // Norm mode codes; any other value yields zero
  localparam logic [ModeWidth-1:0] MODE_MAX_ABS  = 3'd0;
  localparam logic [ModeWidth-1:0] MODE_ONE_NORM = 3'd1;
  localparam logic [ModeWidth-1:0] MODE_INF_NORM = 3'd2;
  localparam logic [ModeWidth-1:0] MODE_FROB     = 3'd3;

  // Classification of an accepted transaction
  typedef enum logic [1:0] {
    KIND_BODY,
    KIND_LAST,
    KIND_EMPTY
  } item_kind_e;

  typedef struct packed {
    item_kind_e             kind;
    logic [ModeWidth-1:0]   mode;
    logic [MagWidth-1:0]    diag_mag;
    logic [MagWidth-1:0]    sub_mag;
    logic [MagWidth-1:0]    sup_mag;
  } entry_t;

  // Square-root unit
  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_RUN,
    SQ_HOLD
  } sqrt_state_e;

  typedef struct packed {
    logic idle;
    logic done;
  } sqrt_stat_t;

  // Magnitude of a two's complement value; the most negative value maps exactly.
  function automatic logic [MagWidth-1:0] mag_of(input logic [DataWidth-1:0] v);
    return v[DataWidth-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

`default_nettype wire

FILE: sv/tmn_if.sv
// Channel interfaces of the tridiagonal matrix norm block: input items
// and norm results, each with valid/ready handshake. Depends on tmn_pkg.
`default_nettype none

interface tmn_in_if;
  import tmn_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [DataWidth-1:0] sub_value;
  logic signed [DataWidth-1:0] diag_value;
  logic signed [DataWidth-1:0] sup_value;
  logic                        last;
  logic                        empty_req;

  modport source (output valid, sub_value, diag_value, sup_value, last, empty_req,
                  input ready);
  modport sink   (input valid, sub_value, diag_value, sup_value, last, empty_req,
                  output ready);
endinterface

interface tmn_out_if;
  import tmn_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [NormWidth-1:0] norm_value;

  modport source (output valid, norm_value, input ready);
  modport sink   (input valid, norm_value, output ready);
endinterface

`default_nettype wire

FILE: sv/tmn_front.sv
// Front end: holds the mode register, accepts input transactions, takes
// magnitudes and classifies each item for the queue. Depends on tmn_pkg, tmn_if.
`default_nettype none

module tmn_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tmn_in_if.sink                        item_i,
  input  logic                          norm_mode_we_i,
  input  logic [tmn_pkg::ModeWidth-1:0] norm_mode_wdata_i,
  output logic                          push_valid_o,
  input  logic                          push_ready_i,
  output tmn_pkg::entry_t               push_data_o
);
  import tmn_pkg::*;

  logic [ModeWidth-1:0] mode_q, mode_d;

  // Mode register, written by the configuration port
  always_comb begin
    mode_d = mode_q;
    if (norm_mode_we_i) begin
      mode_d = norm_mode_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_MAX_ABS;
    end else begin
      mode_q <= mode_d;
    end
  end

  // A transaction is taken whenever the queue has room
  assign item_i.ready = push_ready_i;
  assign push_valid_o = item_i.valid;

  // Classify the item; off-diagonal entries of the final index do not count
  always_comb begin
    push_data_o.mode     = mode_q;
    push_data_o.diag_mag = mag_of(item_i.diag_value);
    push_data_o.sub_mag  = mag_of(item_i.sub_value);
    push_data_o.sup_mag  = mag_of(item_i.sup_value);
    if (item_i.empty_req) begin
      push_data_o.kind = KIND_EMPTY;
    end else if (item_i.last) begin
      push_data_o.kind = KIND_LAST;
    end else begin
      push_data_o.kind = KIND_BODY;
    end
    if (item_i.last) begin
      push_data_o.sub_mag = '0;
      push_data_o.sup_mag = '0;
    end
  end

endmodule

`default_nettype wire

FILE: sv/tmn_fifo.sv
// Short queue of classified items between the front and back ends,
// held in flip-flops. Depends on tmn_pkg.
`default_nettype none

module tmn_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  tmn_pkg::entry_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output tmn_pkg::entry_t pop_data_o
);
  import tmn_pkg::*;

  entry_t            store_q [FifoDepth];
  logic [FifoAw-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoAw-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoAw:0]   count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != (FifoAw + 1)'(FifoDepth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = store_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      store_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: sv/tmn_isqrt.sv
// Bit-serial floor square root of the 64-bit sum of squares, one result
// bit per cycle, with the result saturated to the norm width. Depends on tmn_pkg.
`default_nettype none

module tmn_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [tmn_pkg::AccWidth-1:0]  radicand_i,
  input  logic                          ack_i,
  output tmn_pkg::sqrt_stat_t           stat_o,
  output logic [tmn_pkg::NormWidth-1:0] root_o
);
  import tmn_pkg::*;

  sqrt_state_e           state_q, state_d;
  logic [AccWidth-1:0]   opnd_q;
  logic [RootWidth:0]    rem_q;
  logic [RootWidth-1:0]  root_q;
  logic [CntWidth-1:0]   cnt_q;
  logic [RootWidth+2:0]  rem_sh;
  logic [RootWidth+2:0]  trial;
  logic [RootWidth+2:0]  diff;
  logic                  fits;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      SQ_IDLE: if (start_i) begin
        state_d = SQ_RUN;
      end
      SQ_RUN: if (cnt_q == '0) begin
        state_d = SQ_HOLD;
      end
      SQ_HOLD: if (ack_i) begin
        state_d = SQ_IDLE;
      end
      default: state_d = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SQ_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Outputs: status and saturated root
  always_comb begin
    stat_o.idle = (state_q == SQ_IDLE);
    stat_o.done = (state_q == SQ_HOLD);
    if (root_q[RootWidth-1:NormWidth] != '0) begin
      root_o = '1;
    end else begin
      root_o = root_q[NormWidth-1:0];
    end
  end

  // One restoring step: bring down two radicand bits and try the next root bit
  assign rem_sh = {rem_q, opnd_q[AccWidth-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign fits   = (rem_sh >= trial);
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk_i) begin
    if (state_q == SQ_IDLE && start_i) begin
      opnd_q <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= CntWidth'(RootWidth - 1);
    end else if (state_q == SQ_RUN) begin
      opnd_q <= {opnd_q[AccWidth-3:0], 2'b00};
      rem_q  <= fits ? diff[RootWidth:0] : rem_sh[RootWidth:0];
      root_q <= {root_q[RootWidth-2:0], fits};
      cnt_q  <= cnt_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: sv/tmn_back.sv
// Back end: squares the queued magnitudes, keeps the running maximum,
// line sums and sum of squares, and delivers results through an output
// register. Depends on tmn_pkg, tmn_if and tmn_isqrt.
`default_nettype none

module tmn_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pop_valid_i,
  output logic            pop_ready_o,
  input  tmn_pkg::entry_t pop_data_i,
  tmn_out_if.source       result_o
);
  import tmn_pkg::*;

  // Square stage
  logic                 sa_valid_q, sa_valid_d;
  entry_t               sa_entry_q;
  logic [SqWidth-1:0]   sq_d_q, sq_s_q, sq_u_q;
  logic                 pop;

  // Accumulators
  logic [MagWidth-1:0]  prev_sub_q, prev_sup_q;
  logic [MaxWidth-1:0]  rmax_q;
  logic [AccWidth-1:0]  ss_q;

  // Accumulate stage
  logic                 b_fire;
  logic                 is_term;
  logic                 is_frob_last;
  logic                 is_max_mode;
  logic [MaxWidth-1:0]  cand;
  logic [MaxWidth-1:0]  rmax_upd;
  logic [SqSumWidth-1:0] sq_sum;
  logic [AccWidth:0]    ss_ext;
  logic [AccWidth-1:0]  ss_upd;
  logic [NormWidth-1:0] direct_res;

  // Output register and square-root hand-off
  logic                 out_valid_q, out_valid_d;
  logic [NormWidth-1:0] norm_q;
  logic                 out_free;
  logic                 direct_load;
  logic                 sqrt_load;
  logic                 sq_start;
  sqrt_stat_t           sq_stat;
  logic [NormWidth-1:0] sq_root;

  // Square stage: register the entry with its three squares
  assign pop_ready_o = !sa_valid_q || b_fire;
  assign pop         = pop_valid_i && pop_ready_o;

  always_comb begin
    sa_valid_d = sa_valid_q;
    if (pop) begin
      sa_valid_d = 1'b1;
    end else if (b_fire) begin
      sa_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_valid_q <= 1'b0;
    end else begin
      sa_valid_q <= sa_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      sa_entry_q <= pop_data_i;
      sq_d_q     <= SqWidth'(pop_data_i.diag_mag) * SqWidth'(pop_data_i.diag_mag);
      sq_s_q     <= SqWidth'(pop_data_i.sub_mag) * SqWidth'(pop_data_i.sub_mag);
      sq_u_q     <= SqWidth'(pop_data_i.sup_mag) * SqWidth'(pop_data_i.sup_mag);
    end
  end

  // Candidate for the running maximum under the item's mode
  always_comb begin
    case (sa_entry_q.mode)
      MODE_MAX_ABS: begin
        cand = MaxWidth'(sa_entry_q.diag_mag);
        if (MaxWidth'(sa_entry_q.sub_mag) > cand) begin
          cand = MaxWidth'(sa_entry_q.sub_mag);
        end
        if (MaxWidth'(sa_entry_q.sup_mag) > cand) begin
          cand = MaxWidth'(sa_entry_q.sup_mag);
        end
      end
      MODE_ONE_NORM: cand = MaxWidth'(sa_entry_q.diag_mag) + MaxWidth'(sa_entry_q.sub_mag)
                            + MaxWidth'(prev_sup_q);
      MODE_INF_NORM: cand = MaxWidth'(sa_entry_q.diag_mag) + MaxWidth'(sa_entry_q.sup_mag)
                            + MaxWidth'(prev_sub_q);
      default:       cand = '0;
    endcase
  end

  assign is_max_mode = (sa_entry_q.mode == MODE_MAX_ABS) ||
                       (sa_entry_q.mode == MODE_ONE_NORM) ||
                       (sa_entry_q.mode == MODE_INF_NORM);
  assign rmax_upd    = (is_max_mode && cand > rmax_q) ? cand : rmax_q;

  // Saturating sum of squares
  assign sq_sum = SqSumWidth'(sq_d_q) + SqSumWidth'(sq_s_q) + SqSumWidth'(sq_u_q);
  assign ss_ext = {1'b0, ss_q} + (AccWidth + 1)'(sq_sum);

  always_comb begin
    ss_upd = ss_q;
    if (sa_entry_q.mode == MODE_FROB) begin
      ss_upd = ss_ext[AccWidth] ? '1 : ss_ext[AccWidth-1:0];
    end
  end

  // Terminal items either start the square root or give a result at once
  assign is_term      = (sa_entry_q.kind != KIND_BODY);
  assign is_frob_last = (sa_entry_q.kind == KIND_LAST) && (sa_entry_q.mode == MODE_FROB);
  assign out_free     = !out_valid_q || result_o.ready;

  always_comb begin
    b_fire = 1'b0;
    if (sa_valid_q) begin
      if (!is_term) begin
        b_fire = 1'b1;
      end else if (is_frob_last) begin
        b_fire = sq_stat.idle;
      end else begin
        b_fire = sq_stat.idle && out_free;
      end
    end
  end

  always_comb begin
    direct_res = '0;
    if (sa_entry_q.kind == KIND_LAST && is_max_mode) begin
      direct_res = NormWidth'(rmax_upd);
    end
  end

  assign sq_start    = b_fire && is_frob_last;
  assign direct_load = b_fire && is_term && !is_frob_last;
  assign sqrt_load   = sq_stat.done && out_free;

  // Accumulator update; every result clears the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_sub_q <= '0;
      prev_sup_q <= '0;
      rmax_q     <= '0;
      ss_q       <= '0;
    end else if (b_fire) begin
      if (is_term) begin
        prev_sub_q <= '0;
        prev_sup_q <= '0;
        rmax_q     <= '0;
        ss_q       <= '0;
      end else begin
        prev_sub_q <= sa_entry_q.sub_mag;
        prev_sup_q <= sa_entry_q.sup_mag;
        rmax_q     <= rmax_upd;
        ss_q       <= ss_upd;
      end
    end
  end

  tmn_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (ss_upd),
    .ack_i      (sqrt_load),
    .stat_o     (sq_stat),
    .root_o     (sq_root)
  );

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (direct_load || sqrt_load) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (direct_load) begin
      norm_q <= direct_res;
    end else if (sqrt_load) begin
      norm_q <= sq_root;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.norm_value = norm_q;

  // Checks
  a_single_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(direct_load && sqrt_load))
    else $error("direct result and square root loaded together");

  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_start |-> sq_stat.idle)
    else $error("square root started while busy");

  a_direct_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    direct_load |-> out_free)
    else $error("result loaded over an undelivered result");

  a_clear_after_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_fire && is_term) |=> (rmax_q == '0 && ss_q == '0 &&
                             prev_sub_q == '0 && prev_sup_q == '0))
    else $error("accumulators not cleared after a result");

endmodule

`default_nettype wire

FILE: sv/tridiagonal_matrix_norm.sv
// Tridiagonal matrix norm: top level joining front end, queue and back end.
// Depends on tmn_pkg, tmn_if, tmn_front, tmn_fifo and tmn_back.
//
// The matrix streams in one index per transaction (sub, diagonal and
// super-diagonal entries, signed Q8.16), and the transaction flagged last
// yields one result; a transaction with empty_req yields zero at once.
// Body items are taken one per cycle while the queue has room, since a
// waiting terminal item can hold the flow, and pass through a four-entry
// queue, a squaring stage and an accumulate stage. Maximum-absolute,
// one-norm and infinity-norm results go straight to the output register.
// A Frobenius result first goes through a bit-serial square root, one root
// bit per cycle; meanwhile the next matrix keeps streaming in and
// accumulating, and only its own terminal item waits for the square root
// to finish. Write norm_mode only while no matrix is in flight.
`default_nettype none

module tridiagonal_matrix_norm (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tmn_in_if.sink                        item_i,
  tmn_out_if.source                     result_o,
  input  logic                          norm_mode_we_i,
  input  logic [tmn_pkg::ModeWidth-1:0] norm_mode_wdata_i
);
  import tmn_pkg::*;

  logic   push_valid, push_ready;
  entry_t push_data;
  logic   pop_valid, pop_ready;
  entry_t pop_data;

  tmn_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .item_i            (item_i),
    .norm_mode_we_i    (norm_mode_we_i),
    .norm_mode_wdata_i (norm_mode_wdata_i),
    .push_valid_o      (push_valid),
    .push_ready_i      (push_ready),
    .push_data_o       (push_data)
  );

  tmn_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  tmn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire
